// ===== rtl/core/esc_pkg.sv =====
`default_nettype none

package esc_pkg;

    // Parser modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_HEX1   = 3'd2;
    localparam logic [2:0] MODE_HEX2   = 3'd3;
    localparam logic [2:0] MODE_ERROR  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRAIL_BSL = 3'd1;
    localparam logic [2:0] ST_HEX_SHORT = 3'd2;
    localparam logic [2:0] ST_BAD_HEX   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_HEX_INTRO = 8'h78;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_string;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       end_of_string;
    } out_word_t;

    typedef struct packed {
        logic [2:0] parse_mode;
        logic [3:0] high_nibble;
        logic       high_digit_ok;
        logic [2:0] error_code;
    } parse_state_t;

    // Returns {valid, nibble} for an ASCII hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
                hex_value = {1'b1, d[3:0]};
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - 8'h57;
                hex_value = {1'b1, d[3:0]};
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h37;
                hex_value = {1'b1, d[3:0]};
            end else begin
                hex_value = 5'd0;
            end
        end
    endfunction

    // Returns {known, byte} for a single-character escape.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            8'h6E:   simple_escape = {1'b1, 8'd10};  // n
            8'h72:   simple_escape = {1'b1, 8'd13};  // r
            8'h61:   simple_escape = {1'b1, 8'd7};   // a
            8'h74:   simple_escape = {1'b1, 8'd9};   // t
            8'h62:   simple_escape = {1'b1, 8'd8};   // b
            8'h65:   simple_escape = {1'b1, 8'd27};  // e
            8'h30:   simple_escape = {1'b1, 8'd0};   // zero
            8'h5C:   simple_escape = {1'b1, 8'd92};  // backslash
            8'h22:   simple_escape = {1'b1, 8'd34};  // double quote
            default: simple_escape = 9'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esc_parser.sv =====
`default_nettype none

module esc_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire esc_pkg::in_word_t in_word,
    output esc_pkg::out_word_t     out_word
);
    import esc_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;

    logic [4:0] hex_res;
    logic [8:0] esc_res;
    logic [2:0] mode_next;
    logic [2:0] status;
    logic [7:0] obyte;
    logic       valid;
    logic       last;

    assign hex_res = hex_value(in_word.in_byte);
    assign esc_res = simple_escape(in_word.in_byte);
    assign last    = in_word.last_of_string;

    always_comb begin
        state_next = state_reg;
        mode_next  = state_reg.parse_mode;
        status     = ST_OK;
        obyte      = 8'd0;
        valid      = 1'b0;

        case (state_reg.parse_mode)
            MODE_ESCAPE: begin
                if (esc_res[8]) begin
                    obyte     = esc_res[7:0];
                    valid     = 1'b1;
                    mode_next = MODE_NORMAL;
                end else if (in_word.in_byte == CHAR_HEX_INTRO) begin
                    if (last) begin
                        status = ST_HEX_SHORT;
                    end else begin
                        mode_next = MODE_HEX1;
                    end
                end else begin
                    status = ST_UNKNOWN;
                end
            end
            MODE_HEX1: begin
                state_next.high_digit_ok = hex_res[4];
                state_next.high_nibble   = hex_res[3:0];
                if (last) begin
                    status = ST_HEX_SHORT;
                end else begin
                    mode_next = MODE_HEX2;
                end
            end
            MODE_HEX2: begin
                if (hex_res[4] && state_reg.high_digit_ok) begin
                    obyte     = {state_reg.high_nibble, hex_res[3:0]};
                    valid     = 1'b1;
                    mode_next = MODE_NORMAL;
                end else begin
                    status = ST_BAD_HEX;
                end
            end
            MODE_ERROR: begin
                status = state_reg.error_code;
            end
            default: begin
                // Plain text, and the unused mode codes behave the same way.
                if (in_word.in_byte == CHAR_BACKSLASH) begin
                    if (last) begin
                        status = ST_TRAIL_BSL;
                    end else begin
                        mode_next = MODE_ESCAPE;
                    end
                end else begin
                    obyte     = in_word.in_byte;
                    valid     = 1'b1;
                    mode_next = MODE_NORMAL;
                end
            end
        endcase

        if (status != ST_OK) begin
            mode_next             = MODE_ERROR;
            state_next.error_code = status;
        end
        if (last) begin
            mode_next             = MODE_NORMAL;
            state_next.error_code = ST_OK;
        end
        state_next.parse_mode = mode_next;

        out_word.out_byte      = obyte;
        out_word.byte_valid    = valid;
        out_word.status        = status;
        out_word.end_of_string = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    // The end of a string always leaves the parser clean.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && in_word.last_of_string
        |=> state_reg.parse_mode == MODE_NORMAL && state_reg.error_code == ST_OK)
        else $error("parser not back in normal mode after end of string");

    // Error mode always has a non-zero code to repeat.
    a_error_code: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.parse_mode == MODE_ERROR |-> state_reg.error_code != ST_OK)
        else $error("error mode without an error code");

    // A decoded byte never comes with an error status.
    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && out_word.byte_valid |-> out_word.status == ST_OK)
        else $error("decoded byte carries an error status");

endmodule

`default_nettype wire

// ===== rtl/core/escape_sequence_decoder_top.sv =====
`default_nettype none

// Backslash escape decoder. Each input word is one raw byte of a string plus
// a flag on its final byte; each input word gives exactly one result word,
// carrying an optional decoded byte, a status and a copy of the flag. The
// escapes recognised are \n \r \a \t \b \e \0 \\ \" and \x followed by two hex
// digits. On a trailing backslash, a truncated hex escape, a bad hex digit or
// an unknown escape the error is reported and then repeated on every further
// word of the same string with no byte; the parser is clean again after the
// final byte. The block takes one word per clock cycle at a sustained rate
// while the result side takes its words. An accepted input word is held in
// the input register; once the output register is free or its word is being
// taken, the parser decodes it in one pass of combinational logic against its
// small state register, and the output register holds the result, offered on
// m_valid, until it is taken. Back-pressure on the result side stalls the
// input register, and s_ready then drops.
module escape_sequence_decoder_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire esc_pkg::in_word_t  s_word,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      esc_pkg::out_word_t m_word
);
    import esc_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    out_word_t step_word;
    logic      advance;

    // A word moves through the parser when the output register is free or
    // its current word is being taken in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    esc_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .in_word  (in_word_reg),
        .out_word (step_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg <= step_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    // An empty input register must always be able to take a word.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // A result word that is not taken stays on offer unchanged.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word dropped or changed while waiting");

    // A word that passes through the parser is offered in the next cycle.
    a_result_offered: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("decoded word not offered");

endmodule

`default_nettype wire

// ===== tb/tb_escape_sequence_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_escape_sequence_decoder_top;
    import esc_pkg::*;

    // Run limits. The cycle limit leaves a wide margin over a correct run before
    // the run is declared hung.
    localparam int CYCLE_LIMIT      = 200000;
    localparam int WORDS_PER_PHASE  = 150;
    localparam int HOLD_OFF_CYCLES  = 40;
    localparam int DRAIN_CYCLES     = 10;

    // A directed row either carries its result typed in by hand, or leaves
    // the result to the decoder model held in this bench.
    localparam logic TYPED_EXP = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam logic [7:0] SIMPLE_ESCAPES [9] = '{
        "n", "r", "a", "t", "b", "e", "0", CHAR_BACKSLASH, "\""
    };

    typedef struct packed {
        in_word_t  w;
        logic      typed;
        out_word_t exp;
    } directed_row_t;

    // Each row reads: input byte, last flag, typed flag, then the result as
    // out_byte, byte_valid, status and end_of_string. Rows left to the model
    // carry zeros in the result columns.
    localparam directed_row_t DIRECTED [25] = '{
        // Plain bytes at the extremes, the last one closing a string.
        {"A",            1'b0, TYPED_EXP, "A",   1'b1, ST_OK,        1'b0},
        {8'h00,          1'b0, TYPED_EXP, 8'h00, 1'b1, ST_OK,        1'b0},
        {8'hFF,          1'b1, TYPED_EXP, 8'hFF, 1'b1, ST_OK,        1'b1},
        // A backslash on its own as the final byte.
        {CHAR_BACKSLASH, 1'b1, TYPED_EXP, 8'h00, 1'b0, ST_TRAIL_BSL, 1'b1},
        // A simple newline escape.
        {CHAR_BACKSLASH, 1'b0, TYPED_EXP, 8'h00, 1'b0, ST_OK,        1'b0},
        {"n",            1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        // A complete hex escape with mixed-case digits, closing the string.
        {CHAR_BACKSLASH, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {CHAR_HEX_INTRO, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {"A",            1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {"f",            1'b1, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        // The string ends straight after the x.
        {CHAR_BACKSLASH, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {CHAR_HEX_INTRO, 1'b1, TYPED_EXP, 8'h00, 1'b0, ST_HEX_SHORT, 1'b1},
        // The string ends on the first hex digit.
        {CHAR_BACKSLASH, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {CHAR_HEX_INTRO, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {"4",            1'b1, TYPED_EXP, 8'h00, 1'b0, ST_HEX_SHORT, 1'b1},
        // A bad first digit, only reported once the second has arrived, and
        // then repeated on the rest of the string.
        {CHAR_BACKSLASH, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {CHAR_HEX_INTRO, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {"g",            1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {"1",            1'b0, TYPED_EXP, 8'h00, 1'b0, ST_BAD_HEX,   1'b0},
        {"z",            1'b1, TYPED_EXP, 8'h00, 1'b0, ST_BAD_HEX,   1'b1},
        // An unknown escape, repeated on the closing byte.
        {CHAR_BACKSLASH, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {"q",            1'b0, TYPED_EXP, 8'h00, 1'b0, ST_UNKNOWN,   1'b0},
        {"w",            1'b1, TYPED_EXP, 8'h00, 1'b0, ST_UNKNOWN,   1'b1},
        // An escaped backslash as the final pair.
        {CHAR_BACKSLASH, 1'b0, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0},
        {CHAR_BACKSLASH, 1'b1, PREDICTED, 8'h00, 1'b0, ST_OK,        1'b0}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // Copy of the parser state, advanced once for every accepted input word.
    logic [2:0] model_mode     = MODE_NORMAL;
    logic [3:0] model_high     = 4'd0;
    logic       model_high_ok  = 1'b0;
    logic [2:0] model_error    = ST_OK;

    out_word_t  pending_results[$];
    out_word_t  oldest_result;
    int         words_sent     = 0;
    int         fail_count     = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_off_req   = 1'b0;

    escape_sequence_decoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Returns whether the byte is a hex digit, and its value in nibble.
    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] nibble);
        logic [7:0] d;
        d = 8'd0;
        hex_digit = 1'b1;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
        end else begin
            hex_digit = 1'b0;
        end
        nibble = d[3:0];
    endfunction

    // Works out the result word that one input word causes, and moves the
    // parser copy on to its next state.
    function automatic out_word_t decode_step(input in_word_t w);
        out_word_t  r;
        logic [2:0] next_mode;
        logic [3:0] nibble;
        logic       is_hex;
        logic [7:0] c;
        c = w.in_byte;
        r = '0;
        r.end_of_string = w.last_of_string;
        next_mode = model_mode;
        case (model_mode)
            MODE_ESCAPE: begin
                r.byte_valid = 1'b1;
                next_mode = MODE_NORMAL;
                case (c)
                    "n":            r.out_byte = 8'd10;
                    "r":            r.out_byte = 8'd13;
                    "a":            r.out_byte = 8'd7;
                    "t":            r.out_byte = 8'd9;
                    "b":            r.out_byte = 8'd8;
                    "e":            r.out_byte = 8'd27;
                    "0":            r.out_byte = 8'd0;
                    CHAR_BACKSLASH: r.out_byte = CHAR_BACKSLASH;
                    "\"":           r.out_byte = "\"";
                    default: begin
                        r.byte_valid = 1'b0;
                        next_mode = MODE_ESCAPE;
                        if (c == CHAR_HEX_INTRO) begin
                            if (w.last_of_string) r.status = ST_HEX_SHORT;
                            else next_mode = MODE_HEX1;
                        end else begin
                            r.status = ST_UNKNOWN;
                        end
                    end
                endcase
            end
            MODE_HEX1: begin
                model_high_ok = hex_digit(c, nibble);
                model_high = nibble;
                if (w.last_of_string) r.status = ST_HEX_SHORT;
                else next_mode = MODE_HEX2;
            end
            MODE_HEX2: begin
                is_hex = hex_digit(c, nibble);
                if (is_hex && model_high_ok) begin
                    r.out_byte = {model_high, nibble};
                    r.byte_valid = 1'b1;
                    next_mode = MODE_NORMAL;
                end else begin
                    r.status = ST_BAD_HEX;
                end
            end
            MODE_ERROR: begin
                r.status = model_error;
            end
            default: begin
                // Normal text, which also covers the unused mode codes.
                if (c == CHAR_BACKSLASH) begin
                    if (w.last_of_string) r.status = ST_TRAIL_BSL;
                    else next_mode = MODE_ESCAPE;
                end else begin
                    r.out_byte = c;
                    r.byte_valid = 1'b1;
                    next_mode = MODE_NORMAL;
                end
            end
        endcase
        if (r.status != ST_OK) begin
            next_mode = MODE_ERROR;
            model_error = r.status;
        end
        if (w.last_of_string) begin
            next_mode = MODE_NORMAL;
            model_error = ST_OK;
        end
        model_mode = next_mode;
        return r;
    endfunction

    // Offers one input word, holding it steady until it is accepted, and then
    // records the result that it should cause. A typed result from the
    // directed rows takes the place of the model's, though the model is still
    // stepped so that it stays in line with the block.
    task automatic offer_word(input in_word_t w, input logic typed, input out_word_t typed_exp);
        out_word_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predicted = decode_step(w);
        pending_results = {pending_results, (typed ? typed_exp : predicted)};
        words_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        if (nibble < 4'd10) return "0" + nibble;
        return ($urandom_range(1) ? "a" : "A") + nibble - 8'd10;
    endfunction

    // Builds one string out of tokens and sends it with the flag on its final
    // byte. Most tokens are well-formed escapes or plain bytes; the rest are
    // escapes with random bytes, mostly broken ones, and now and then the string
    // is cut off part-way so that it may end inside an escape.
    task automatic send_random_string();
        in_word_t   w;
        logic [7:0] chars[$];
        int         tokens;
        int         kind;
        int         keep;
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                chars = {chars, 8'($urandom_range(255))};
            end else if (kind < 65) begin
                chars = {chars, CHAR_BACKSLASH, SIMPLE_ESCAPES[$urandom_range(8)]};
            end else if (kind < 85) begin
                chars = {chars, CHAR_BACKSLASH, CHAR_HEX_INTRO};
                chars = {chars, hex_char(4'($urandom_range(15)))};
                chars = {chars, hex_char(4'($urandom_range(15)))};
            end else if (kind < 93) begin
                chars = {chars, CHAR_BACKSLASH, 8'($urandom_range(255))};
            end else begin
                chars = {chars, CHAR_BACKSLASH, CHAR_HEX_INTRO};
                chars = {chars, 8'($urandom_range(255)), 8'($urandom_range(255))};
            end
        end
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, chars.size());
            while (chars.size() > keep) void'(chars.pop_back());
        end
        foreach (chars[i]) begin
            w.in_byte = chars[i];
            w.last_of_string = (i == chars.size() - 1);
            offer_word(w, PREDICTED, '0);
        end
    endtask

    task automatic keep_sending(input int target);
        while (words_sent < target) send_random_string();
    endtask

    // The receiver. It stalls at random at the current rate, and once on
    // request it holds off for a long stretch so that the block fills up and
    // has to push back on the sender.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every result word taken is checked against the oldest one still owed.
    // Words are shown as byte, byte_valid, status and end_of_string.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result word with none expected: %h %b %0d %b",
                         $time, m_word.out_byte, m_word.byte_valid, m_word.status,
                         m_word.end_of_string);
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_word.out_byte      !== oldest_result.out_byte   ||
                    m_word.byte_valid    !== oldest_result.byte_valid ||
                    m_word.status        !== oldest_result.status     ||
                    m_word.end_of_string !== oldest_result.end_of_string) begin
                    fail_count++;
                    $display("%0t: mismatch, expected %h %b %0d %b, actual %h %b %0d %b",
                             $time, oldest_result.out_byte, oldest_result.byte_valid,
                             oldest_result.status, oldest_result.end_of_string,
                             m_word.out_byte, m_word.byte_valid, m_word.status,
                             m_word.end_of_string);
                end
            end
        end
    end

    // A watchdog, so that a block that stops answering cannot hang the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // The directed rows run with neither side idling.
        foreach (DIRECTED[i]) begin
            offer_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].exp);
        end

        // Four phases of random strings: no idling, a sender that is often
        // idle, a receiver that often stalls, and both idling a little. The
        // long hold-off on the receiver falls at the start of the first phase,
        // while the sender is offering a word on every cycle.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_off_req   = 1'b1;
                end
                1: begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            keep_sending(words_sent + WORDS_PER_PHASE);
        end
        s_valid <= 1'b0;

        // Wait for every result still owed, then keep watching for a drain period in
        // case the block offers a word that nobody asked for.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
